// ===== hw/rtl/chained_free_block_stack_macros.svh =====
// ----------------------------------------------------------------------------
// chained_free_block_stack assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHAINED_FREE_BLOCK_STACK_MACROS_SVH
`define CHAINED_FREE_BLOCK_STACK_MACROS_SVH

// condition holds at every edge
`define CFS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfs_pkg
// Types and codes of the chained free block stack.
// ----------------------------------------------------------------------------
package cfs_pkg;

    localparam int BLK_W   = 16;
    localparam int PAIR_W  = 32;
    localparam int PIDX_W  = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [1:0] {
        OP_FREE   = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_REFILL = 2'd2
    } cfs_op_t;

    typedef enum logic [2:0] {
        STAT_FREED     = 3'd0,
        STAT_ALLOCATED = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_SPILL     = 3'd3,
        STAT_WR_REJECT = 3'd4,
        STAT_REFILL_RQ = 3'd5,
        STAT_RF_REJECT = 3'd6,
        STAT_RF_WORD   = 3'd7
    } cfs_status_t;

    localparam logic REG_INODE_AREA     = 1'b0;
    localparam logic REG_STORE_WRITABLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_SPILL_RD,
        S_SPILL_WR,
        S_ALLOC,
        S_ALLOC_CHK,
        S_REFILL,
        S_REFILL_DONE
    } cfs_state_t;

    typedef struct packed {
        cfs_status_t        status;
        logic [BLK_W-1:0]   target_block;
        logic [PAIR_W-1:0]  spill_pair;
        logic [PIDX_W-1:0]  pair_index;
        logic               last;
        logic               count_saturated;
        logic               list_dirty;
        logic               store_modified;
    } cfs_result_t;

endpackage

// ===== hw/rtl/cfs_ram.sv =====
// ----------------------------------------------------------------------------
// cfs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/chained_free_block_stack.sv =====
// ----------------------------------------------------------------------------
// chained_free_block_stack
// In-core stack of free block numbers, spilled to and refilled from storage.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  s_axis   in   tvalid/tready          tuser op, tdata fields
//  m_axis   out  tvalid/tready          tuser status, tlast, tdata fields
//  cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  One item at a time; input taken only in idle, a waiting result does not block it.
//  Free: S_FREE. Alloc: S_ALLOC, S_ALLOC_CHK, looped per zero. Refill: S_REFILL.
//  Spill: S_SPILL_RD reads each word via the single RAM read port, two words per beat.
//  Output register stalls the sequencer only when it still holds a beat.
//  Reset clears control state; stack RAM contents are undefined until written.
`include "chained_free_block_stack_macros.svh"

module chained_free_block_stack #(
    parameter int FREE_SLOTS = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] block_number, [31:16] refill_word, [32] refill_failed
    input  logic [cfs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] target_block, [47:16] spill_pair, [53:48] pair_index,
    // [54] count_saturated, [55] list_dirty, [56] store_modified
    output logic [cfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]                    m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_data
);

    import cfs_pkg::*;

    localparam int CW        = $clog2(FREE_SLOTS + 1);
    localparam int AW        = $clog2(FREE_SLOTS);
    localparam int RUN_WORDS = FREE_SLOTS + 1;
    localparam int RUN_PAIRS = (FREE_SLOTS + 2) / 2;
    localparam int WW        = $clog2(2 * RUN_PAIRS);
    localparam int PSW       = $clog2(RUN_WORDS + 1);

    cfs_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pending_reg, pending_next;
    logic [PSW-1:0]    pos_reg, pos_next;
    logic              dirty_reg, dirty_next;
    logic              mod_reg, mod_next;
    logic [BLK_W-1:0]  rblk_reg, rblk_next;
    logic              sat_reg, sat_next;
    logic [WW-1:0]     w_reg, w_next;
    logic [BLK_W-1:0]  lo_reg, lo_next;

    logic [BLK_W-1:0]  inode_reg;
    logic              writable_reg;

    logic [BLK_W-1:0]  blk_reg;
    logic [BLK_W-1:0]  word_reg;
    logic              fail_reg;

    logic              out_valid_reg;
    cfs_result_t       out_reg;
    cfs_result_t       out_next;
    logic              out_load;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BLK_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BLK_W-1:0]  mem_rdata;

    logic              in_fire;
    logic              out_free;
    logic              full;
    logic              blk_protected;
    logic              rd_protected;
    logic              spill_reject;
    logic [BLK_W-1:0]  spill_word;
    logic              last_pair;
    logic [CW-1:0]     cnt_dec;
    logic [PSW-1:0]    pos_inc;
    logic              refill_done;
    logic [16:0]       guard_limit;

    cfs_ram #(
        .WIDTH (BLK_W),
        .DEPTH (FREE_SLOTS)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {7'd0, out_reg.store_modified, out_reg.list_dirty,
                            out_reg.count_saturated, out_reg.pair_index,
                            out_reg.spill_pair, out_reg.target_block};

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign full          = (count_reg == CW'(FREE_SLOTS));
    assign guard_limit   = {1'b0, inode_reg} + 17'd1;
    assign blk_protected = ({1'b0, blk_reg} <= guard_limit);
    assign rd_protected  = ({1'b0, mem_rdata} <= guard_limit);
    assign spill_reject  = !writable_reg || blk_protected;
    assign last_pair     = (w_reg == WW'(2 * RUN_PAIRS - 1));
    assign cnt_dec       = count_reg - 1'b1;
    assign pos_inc       = pos_reg + 1'b1;
    assign refill_done   = (pos_inc == PSW'(RUN_WORDS));

    always_comb
    begin
        if (w_reg == '0)
        begin
            spill_word = BLK_W'(count_reg);
        end
        else if (w_reg <= WW'(FREE_SLOTS))
        begin
            spill_word = mem_rdata;
        end
        else
        begin
            spill_word = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_axis_tuser)
                        OP_FREE:   if (!pending_reg) state_next = S_FREE;
                        OP_ALLOC:  if (!pending_reg) state_next = S_ALLOC;
                        OP_REFILL: if (pending_reg)  state_next = S_REFILL;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_FREE:
            begin
                if (full && !spill_reject)
                begin
                    state_next = S_SPILL_RD;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SPILL_RD:
            begin
                state_next = S_SPILL_WR;
            end
            S_SPILL_WR:
            begin
                if (!w_reg[0])
                begin
                    state_next = S_SPILL_RD;
                end
                else if (out_free)
                begin
                    state_next = last_pair ? S_IDLE : S_SPILL_RD;
                end
            end
            S_ALLOC:
            begin
                if (count_reg != '0)
                begin
                    state_next = S_ALLOC_CHK;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ALLOC_CHK:
            begin
                if (count_reg != '0 && mem_rdata == '0)
                begin
                    state_next = S_ALLOC;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REFILL:
            begin
                if (out_free)
                begin
                    state_next = (!fail_reg && refill_done) ? S_REFILL_DONE : S_IDLE;
                end
            end
            S_REFILL_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and result build
    always_comb
    begin
        count_next   = count_reg;
        pending_next = pending_reg;
        pos_next     = pos_reg;
        dirty_next   = dirty_reg;
        mod_next     = mod_reg;
        rblk_next    = rblk_reg;
        sat_next     = sat_reg;
        w_next       = w_reg;
        lo_next      = lo_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = blk_reg;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        out_load     = 1'b0;
        out_next     = '0;
        out_next.last = 1'b1;

        case (state_reg)
            S_FREE:
            begin
                if (!full)
                begin
                    if (out_free)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(count_reg);
                        count_next = count_reg + 1'b1;
                        dirty_next = 1'b1;
                        out_load   = 1'b1;
                        out_next.status       = STAT_FREED;
                        out_next.target_block = blk_reg;
                    end
                end
                else if (spill_reject)
                begin
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        out_next.status       = STAT_WR_REJECT;
                        out_next.target_block = blk_reg;
                    end
                end
                else
                begin
                    dirty_next = 1'b1;
                    mod_next   = 1'b1;
                    w_next     = '0;
                end
            end
            S_SPILL_RD:
            begin
                mem_re    = (w_reg != '0) && (w_reg <= WW'(FREE_SLOTS));
                mem_raddr = AW'(w_reg - 1'b1);
            end
            S_SPILL_WR:
            begin
                if (!w_reg[0])
                begin
                    lo_next = spill_word;
                    w_next  = w_reg + 1'b1;
                end
                else if (out_free)
                begin
                    w_next   = w_reg + 1'b1;
                    out_load = 1'b1;
                    out_next.status       = STAT_SPILL;
                    out_next.target_block = blk_reg;
                    out_next.spill_pair   = {spill_word, lo_reg};
                    out_next.pair_index   = PIDX_W'(w_reg >> 1);
                    out_next.last         = last_pair;
                    if (last_pair)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        count_next = CW'(1);
                    end
                end
            end
            S_ALLOC:
            begin
                if (count_reg != '0)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(cnt_dec);
                    count_next = cnt_dec;
                    dirty_next = 1'b1;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    out_next.status = STAT_EMPTY;
                end
            end
            S_ALLOC_CHK:
            begin
                if (out_free)
                begin
                    out_next.target_block = mem_rdata;
                    if (count_reg == '0)
                    begin
                        out_load = 1'b1;
                        if (rd_protected)
                        begin
                            out_next.status = STAT_RF_REJECT;
                        end
                        else
                        begin
                            out_next.status = STAT_REFILL_RQ;
                            pending_next = 1'b1;
                            pos_next     = '0;
                            rblk_next    = mem_rdata;
                            sat_next     = 1'b0;
                        end
                    end
                    else if (mem_rdata != '0)
                    begin
                        out_load = 1'b1;
                        out_next.status = STAT_ALLOCATED;
                    end
                end
            end
            S_REFILL:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next.target_block = rblk_reg;
                    if (fail_reg)
                    begin
                        pending_next = 1'b0;
                        pos_next     = '0;
                        count_next   = '0;
                        out_next.status          = STAT_RF_REJECT;
                        out_next.count_saturated = sat_reg;
                    end
                    else
                    begin
                        if (pos_reg == '0)
                        begin
                            if (word_reg > BLK_W'(FREE_SLOTS))
                            begin
                                count_next = CW'(FREE_SLOTS);
                                sat_next   = 1'b1;
                            end
                            else
                            begin
                                count_next = CW'(word_reg);
                            end
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(pos_reg - 1'b1);
                            mem_wdata = word_reg;
                        end
                        pos_next = refill_done ? '0 : pos_inc;
                        if (refill_done)
                        begin
                            pending_next = 1'b0;
                        end
                        out_next.status          = STAT_RF_WORD;
                        out_next.last            = !refill_done;
                        out_next.count_saturated = sat_next;
                    end
                end
            end
            S_REFILL_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_next.status       = STAT_ALLOCATED;
                    out_next.target_block = rblk_reg;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        out_next.list_dirty     = dirty_next;
        out_next.store_modified = mod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pending_reg   <= 1'b0;
            pos_reg       <= '0;
            dirty_reg     <= 1'b0;
            mod_reg       <= 1'b0;
            rblk_reg      <= '0;
            sat_reg       <= 1'b0;
            w_reg         <= '0;
            inode_reg     <= '0;
            writable_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            pos_reg     <= pos_next;
            dirty_reg   <= dirty_next;
            mod_reg     <= mod_next;
            rblk_reg    <= rblk_next;
            sat_reg     <= sat_next;
            w_reg       <= w_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INODE_AREA:     inode_reg    <= cfg_data;
                    REG_STORE_WRITABLE: writable_reg <= cfg_data[0];
                    default:            inode_reg    <= inode_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        if (in_fire)
        begin
            blk_reg  <= s_axis_tdata[15:0];
            word_reg <= s_axis_tdata[31:16];
            fail_reg <= s_axis_tdata[32];
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    `CFS_ASSERT_ALWAYS(a_count_range, count_reg <= CW'(FREE_SLOTS), "stack count past limit")
    `CFS_ASSERT_ALWAYS(a_mem_port, !(mem_we && mem_re), "stack RAM read and write together")
    `CFS_ASSERT_NEXT(a_refill_arm, out_load && out_next.status == STAT_REFILL_RQ, pending_reg && count_reg == '0, "refill request without pending refill")
    `CFS_ASSERT_NEXT(a_spill_end, out_load && out_next.status == STAT_SPILL && out_next.last, count_reg == CW'(1) && state_reg == S_IDLE, "spill end did not leave one entry")

endmodule

// ===== dv/tb_chained_free_block_stack.sv =====
// ----------------------------------------------------------------------------
// tb_chained_free_block_stack
// Self-checking bench for the free block stack: a built-in predictor
// tracks the stack, spill and refill state and queues the expected beats.
// Directed free/allocate/spill/refill cases and a back-pressure stretch run
// first. Random traffic follows under several register settings, with
// random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_chained_free_block_stack;
    timeunit 1ns;
    timeprecision 1ps;

    import cfs_pkg::*;

    localparam int         SLOTS       = 100;
    localparam int         RUN_PAIRS   = (SLOTS + 2) / 2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         DRAIN       = 16;
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam int         MAX_SHOWN   = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = 1'b0;
    logic [15:0]            cfg_data = '0;

    chained_free_block_stack #(.FREE_SLOTS(SLOTS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // predicted block state
    logic [15:0] stack_mem [SLOTS];
    int unsigned stack_depth = 0;
    bit          refill_busy = 1'b0;
    int unsigned refill_pos = 0;
    logic [15:0] refill_src = '0;
    bit          refill_sat = 1'b0;
    bit          list_dirty = 1'b0;
    bit          store_modified = 1'b0;
    logic [15:0] inode_limit = '0;
    bit          store_writable = 1'b1;

    cfs_result_t expected_results [$];
    int          mismatches = 0;
    int          step_results = 0;
    int          cycle_count = 0;
    int          rx_hold_cycles = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    function automatic bit is_protected(logic [15:0] bno);
        return {1'b0, bno} <= {1'b0, inode_limit} + 17'd1;
    endfunction

    function automatic void emit(cfs_status_t st, logic [15:0] tgt, logic [31:0] pair,
                                 logic [5:0] idx, bit last, bit sat);
        cfs_result_t r;
        r.status          = st;
        r.target_block    = tgt;
        r.spill_pair      = pair;
        r.pair_index      = idx;
        r.last            = last;
        r.count_saturated = sat;
        r.list_dirty      = list_dirty;
        r.store_modified  = store_modified;
        expected_results.push_back(r);
    endfunction

    function automatic int push_block(logic [15:0] bno);
        logic [15:0] run_words [2*RUN_PAIRS];
        if (stack_depth < SLOTS)
        begin
            stack_mem[stack_depth] = bno;
            stack_depth++;
            list_dirty = 1'b1;
            emit(STAT_FREED, bno, '0, '0, 1'b1, 1'b0);
            return 1;
        end
        if (!store_writable || is_protected(bno))
        begin
            emit(STAT_WR_REJECT, bno, '0, '0, 1'b1, 1'b0);
            return 1;
        end
        foreach (run_words[i])
            run_words[i] = '0;
        run_words[0] = 16'(stack_depth);
        for (int i = 0; i < SLOTS; i++)
            run_words[i+1] = stack_mem[i];
        store_modified = 1'b1;
        stack_mem[0]   = bno;
        stack_depth    = 1;
        list_dirty     = 1'b1;
        for (int p = 0; p < RUN_PAIRS; p++)
            emit(STAT_SPILL, bno, {run_words[2*p+1], run_words[2*p]}, 6'(p),
                 p == RUN_PAIRS - 1, 1'b0);
        return RUN_PAIRS;
    endfunction

    function automatic int pop_block();
        logic [15:0] bno;
        while (stack_depth != 0)
        begin
            stack_depth--;
            bno = stack_mem[stack_depth];
            stack_mem[stack_depth] = '0;
            list_dirty = 1'b1;
            if (stack_depth == 0)
            begin
                if (is_protected(bno))
                begin
                    emit(STAT_RF_REJECT, bno, '0, '0, 1'b1, 1'b0);
                    return 1;
                end
                refill_busy = 1'b1;
                refill_pos  = 0;
                refill_src  = bno;
                refill_sat  = 1'b0;
                emit(STAT_REFILL_RQ, bno, '0, '0, 1'b1, 1'b0);
                return 1;
            end
            if (bno != 0)
            begin
                emit(STAT_ALLOCATED, bno, '0, '0, 1'b1, 1'b0);
                return 1;
            end
        end
        emit(STAT_EMPTY, '0, '0, '0, 1'b1, 1'b0);
        return 1;
    endfunction

    function automatic int take_refill_word(logic [15:0] word, bit failed);
        if (failed)
        begin
            refill_busy = 1'b0;
            refill_pos  = 0;
            stack_depth = 0;
            emit(STAT_RF_REJECT, refill_src, '0, '0, 1'b1, refill_sat);
            return 1;
        end
        if (refill_pos == 0)
        begin
            if (word > SLOTS)
            begin
                stack_depth = SLOTS;
                refill_sat  = 1'b1;
            end
            else
                stack_depth = word;
        end
        else
            stack_mem[refill_pos-1] = word;
        refill_pos++;
        if (refill_pos < SLOTS + 1)
        begin
            emit(STAT_RF_WORD, refill_src, '0, '0, 1'b1, refill_sat);
            return 1;
        end
        refill_busy = 1'b0;
        refill_pos  = 0;
        emit(STAT_RF_WORD, refill_src, '0, '0, 1'b0, refill_sat);
        emit(STAT_ALLOCATED, refill_src, '0, '0, 1'b1, 1'b0);
        return 2;
    endfunction

    function automatic int predict_step(logic [1:0] op, logic [15:0] bno,
                                        logic [15:0] word, bit failed);
        if (op == OP_REFILL)
            return refill_busy ? take_refill_word(word, failed) : 0;
        if (refill_busy || op == OP_UNUSED)
            return 0;
        if (op == OP_FREE)
            return push_block(bno);
        return pop_block();
    endfunction

    function automatic string show_result(cfs_result_t r);
        return $sformatf("st=%0d blk=%h pair=%h idx=%0d last=%b sat=%b dirty=%b mod=%b",
                         r.status, r.target_block, r.spill_pair, r.pair_index, r.last,
                         r.count_saturated, r.list_dirty, r.store_modified);
    endfunction

    function automatic int tx_gap();
        int roll = $urandom_range(0, 99);
        if (!tx_idle_on || roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_block();
        int roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return (inode_limit == 16'hFFFF) ? 16'($urandom_range(0, 16'hFFFF))
                                             : 16'($urandom_range(0, inode_limit + 1));
        if (roll < 20)
            return 16'hFFFF;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [15:0] pick_entry();
        return ($urandom_range(0, 99) < 15) ? 16'h0 : 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [15:0] pick_count();
        int roll = $urandom_range(0, 99);
        if (roll < 30)
            return 16'(SLOTS);
        if (roll < 45)
            return 16'($urandom_range(SLOTS + 1, 16'hFFFF));
        if (roll < 55)
            return '0;
        return 16'($urandom_range(1, SLOTS));
    endfunction

    task automatic send_item(logic [1:0] op, logic [15:0] bno, logic [15:0] word, bit failed);
        int gap;
        gap = tx_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'b0, failed, word, bno};
        do @(posedge clk); while (!s_axis_tready);
        step_results = predict_step(op, bno, word, failed);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_INODE_AREA)
            inode_limit = val;
        else
            store_writable = val[0];
    endtask

    task automatic complete_refill(logic [15:0] count_word, bit zero_bottom);
        send_item(OP_REFILL, '0, count_word, 1'b0);
        for (int i = 1; i <= SLOTS; i++)
            send_item(OP_REFILL, '0, (i == 1 && zero_bottom) ? 16'h0 : pick_entry(), 1'b0);
    endtask

    task automatic test_empty_and_edges();
        send_item(OP_ALLOC, '0, '0, 1'b0);
        send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(OP_REFILL, '0, 16'hFFFF, 1'b1);
        send_item(OP_REFILL, '0, 16'h0, 1'b0);
        send_item(OP_FREE, 16'h0, '0, 1'b0);
        send_item(OP_FREE, 16'hFFFF, '0, 1'b0);
        send_item(OP_FREE, 16'h1, '0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
        // zero left at the bottom: refill source counts as protected
        send_item(OP_ALLOC, '0, '0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
    endtask

    task automatic test_refill_paths();
        // zero entries skipped on the way down
        send_item(OP_FREE, 16'd500, '0, 1'b0);
        send_item(OP_FREE, 16'h0, '0, 1'b0);
        send_item(OP_FREE, 16'h0, '0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
        // requests while the refill is open are dropped
        send_item(OP_FREE, 16'd7, '0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
        send_item(OP_UNUSED, '0, '0, 1'b0);
        send_item(OP_REFILL, '0, '0, 1'b1);
        send_item(OP_ALLOC, '0, '0, 1'b0);
        // saturated count, then read failure
        send_item(OP_FREE, 16'd600, '0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
        send_item(OP_REFILL, '0, 16'd200, 1'b0);
        send_item(OP_REFILL, '0, 16'd11, 1'b0);
        send_item(OP_REFILL, '0, 16'd12, 1'b1);
        // small count, zero at the bottom
        send_item(OP_FREE, 16'd700, '0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
        complete_refill(16'd3, 1'b1);
        repeat (4) send_item(OP_ALLOC, '0, '0, 1'b0);
        // empty refill
        send_item(OP_FREE, 16'd800, '0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
        complete_refill(16'd0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
    endtask

    task automatic test_spill_and_protection();
        while (refill_busy)
            send_item(OP_REFILL, '0, '0, 1'b1);
        send_item(OP_FREE, 16'd900, '0, 1'b0);
        while (stack_depth != 0 || refill_busy)
        begin
            if (refill_busy)
                send_item(OP_REFILL, '0, '0, 1'b1);
            else
                send_item(OP_ALLOC, '0, '0, 1'b0);
        end
        send_item(OP_FREE, 16'd900, '0, 1'b0);
        send_item(OP_ALLOC, '0, '0, 1'b0);
        complete_refill(16'(SLOTS + 1), 1'b0);
        write_reg(REG_STORE_WRITABLE, 16'd0);
        send_item(OP_FREE, 16'd1234, '0, 1'b0);
        write_reg(REG_STORE_WRITABLE, 16'd1);
        write_reg(REG_INODE_AREA, 16'hFFFF);
        send_item(OP_FREE, 16'hFFFF, '0, 1'b0);
        write_reg(REG_INODE_AREA, 16'd1000);
        send_item(OP_FREE, 16'd1001, '0, 1'b0);
        send_item(OP_FREE, 16'd1002, '0, 1'b0);
        while (stack_depth < SLOTS)
            send_item(OP_FREE, pick_block(), 16'($urandom_range(0, 16'hFFFF)),
                      1'($urandom_range(0, 1)));
        send_item(OP_FREE, 16'hFFFE, '0, 1'b0);
        write_reg(REG_INODE_AREA, 16'd0);
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_hold_cycles = 400;
        for (int i = 0; i < 40; i++)
        begin
            if (i < 30)
                send_item(OP_FREE, pick_block(), '0, 1'b0);
            else
                send_item(OP_ALLOC, '0, '0, 1'b0);
        end
        tx_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic random_traffic(int target);
        int          done_items;
        int          sent;
        int          fail_at;
        int          roll;
        logic [1:0]  op;
        logic [15:0] bno;
        logic [15:0] word;
        bit          failed;
        done_items = 0;
        sent = 0;
        fail_at = -1;
        while (done_items < target)
        begin
            if (sent % 30 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            roll   = $urandom_range(0, 99);
            bno    = $urandom_range(0, 16'hFFFF);
            word   = $urandom_range(0, 16'hFFFF);
            failed = $urandom_range(0, 1);
            if (refill_busy)
            begin
                if (refill_pos == 0)
                    fail_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, SLOTS)) : -1;
                if (roll < 4)
                    op = (roll < 2) ? OP_UNUSED : 2'($urandom_range(0, 1));
                else
                begin
                    op     = OP_REFILL;
                    word   = (refill_pos == 0) ? pick_count() : pick_entry();
                    failed = (int'(refill_pos) == fail_at);
                end
            end
            else if (roll < 3)
                op = OP_UNUSED;
            else if (roll < 6)
                op = OP_REFILL;
            else if (roll < (((sent / 60) % 2 == 0) ? 72 : 38))
            begin
                op  = OP_FREE;
                bno = pick_block();
            end
            else
                op = OP_ALLOC;
            send_item(op, bno, word, failed);
            sent++;
            if (step_results > 0)
                done_items++;
        end
    endtask

    task automatic test_random_phases();
        write_reg(REG_INODE_AREA, 16'd0);
        write_reg(REG_STORE_WRITABLE, 16'd1);
        random_traffic(80);
        write_reg(REG_INODE_AREA, 16'($urandom_range(2, 3000)));
        random_traffic(60);
        write_reg(REG_STORE_WRITABLE, 16'd0);
        random_traffic(40);
        write_reg(REG_INODE_AREA, 16'hFFFF);
        write_reg(REG_STORE_WRITABLE, 16'd1);
        random_traffic(20);
        write_reg(REG_INODE_AREA, 16'd0);
        random_traffic(50);
    endtask

    // result checker
    always @(posedge clk)
    begin
        cfs_result_t got;
        cfs_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status          = cfs_status_t'(m_axis_tuser);
            got.target_block    = m_axis_tdata[15:0];
            got.spill_pair      = m_axis_tdata[47:16];
            got.pair_index      = m_axis_tdata[53:48];
            got.count_saturated = m_axis_tdata[54];
            got.list_dirty      = m_axis_tdata[55];
            got.store_modified  = m_axis_tdata[56];
            got.last            = m_axis_tlast;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected beat: %s", show_result(got));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.target_block !== want.target_block ||
                    got.spill_pair !== want.spill_pair || got.pair_index !== want.pair_index ||
                    got.last !== want.last || got.count_saturated !== want.count_saturated ||
                    got.list_dirty !== want.list_dirty ||
                    got.store_modified !== want.store_modified)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch\n  exp: %s\n  got: %s",
                                 show_result(want), show_result(got));
                end
            end
        end
    end

    // receiver ready, with random stalls and requested hold-offs
    initial
    begin
        int stall;
        int roll;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                roll = $urandom_range(0, 99);
                if (rx_idle_on && roll < 25)
                    stall = (roll < 23) ? $urandom_range(1, 3) : $urandom_range(10, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** chained_free_block_stack: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_edges();
        test_refill_paths();
        test_spill_and_protection();
        test_backpressure();
        test_random_phases();
        wait_idle();
        repeat (DRAIN) @(posedge clk);
        if (expected_results.size() != 0)
            $display("%0d expected beats never arrived", expected_results.size());
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** chained_free_block_stack: PASSED **");
        else
            $display("** chained_free_block_stack: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cfs_pkg.sv
hw/rtl/cfs_ram.sv
hw/rtl/chained_free_block_stack.sv
dv/tb_chained_free_block_stack.sv
